FILE: design/tnst_pkg.sv
// ----------------------------------------------------------------------------
// tnst_pkg: shared types and constants for the neighbor table
// Table geometry, operation and status codes, sequencer states and the
// wrap-aware time compare.
// ----------------------------------------------------------------------------
package tnst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int ADDR_BITS   = 32;
  localparam int HOLD_BITS   = 32;
  localparam int STATUS_BITS = 3;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [HOLD_BITS-1:0] HOLD_RESET = HOLD_BITS'(6);

  // request operations
  typedef enum logic [1:0] {
    OP_ADVERTISE = 2'd0,
    OP_EXPIRE    = 2'd1,
    OP_DELETE    = 2'd2,
    OP_RESERVED  = 2'd3
  } opcode_e;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_INSERTED     = 3'd0,
    STAT_REFRESHED    = 3'd1,
    STAT_DROPPED      = 3'd2,
    STAT_DELETED      = 3'd3,
    STAT_NOT_FOUND    = 3'd4,
    STAT_EXPIRED      = 3'd5,
    STAT_NONE_EXPIRED = 3'd6
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // expiry lies before now when the wrapped difference is negative
  function automatic logic is_before(input logic [TIME_BITS-1:0] expiry,
                                     input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] diff;
    diff = expiry - now;
    return diff[TIME_BITS-1];
  endfunction

endpackage

FILE: design/tnst_if.sv
// ----------------------------------------------------------------------------
// tnst_if: request and result channels of the neighbor table
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface tnst_req_if import tnst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [ADDR_BITS-1:0] neighbor_address;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, output opcode, output neighbor_address,
                  output now_time, input ready);
  modport sink   (input valid, input opcode, input neighbor_address,
                  input now_time, output ready);
endinterface

interface tnst_rsp_if import tnst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ADDR_BITS-1:0]   result_address;
  logic [STATUS_BITS-1:0] status;
  logic                   set_changed;
  logic                   last;

  modport source (output valid, output result_address, output status,
                  output set_changed, output last, input ready);
  modport sink   (input valid, input result_address, input status,
                  input set_changed, input last, output ready);
endinterface

FILE: design/timed_neighbor_selector_table_core.sv
// A request runs a scan state, one entry per cycle through the shared compare
//   unit while not stalled, then a finish state that registers its last result.
// The block takes no new request until it is idle again; an expire stalls its
//   scan while it finds a further expired entry and the output register holds
//   a result that has not been taken, and the finish state waits until the
//   output register is free. Opcode 3 is accepted and gives no result.
// Reset: table empty, hold_time 6; no clearing pass is needed.
// ----------------------------------------------------------------------------
// timed_neighbor_selector_table_core: aging neighbor address table
// Advertise, expire and delete requests against a 16-entry table, each
// resolved by a sequential scan through one address/time compare unit.
// ----------------------------------------------------------------------------
module timed_neighbor_selector_table_core import tnst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [HOLD_BITS-1:0] cfg_wdata_i,
  tnst_req_if.sink             req,
  tnst_rsp_if.source           rsp
);

  // sequencer and request registers
  state_e                 state_q, state_d;
  logic [IDX_BITS-1:0]    idx_q, idx_d;
  opcode_e                op_q, op_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [TIME_BITS-1:0]   expiry_q, expiry_d;
  logic [HOLD_BITS-1:0]   hold_q;

  // scan findings
  logic                   hit_q, hit_d;
  logic [IDX_BITS-1:0]    hit_idx_q, hit_idx_d;
  logic                   free_q, free_d;
  logic [IDX_BITS-1:0]    free_idx_q, free_idx_d;
  logic                   pend_q, pend_d;
  logic [ADDR_BITS-1:0]   pend_addr_q, pend_addr_d;

  // table storage
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [ADDR_BITS-1:0]   addr_mem [TABLE_DEPTH];
  logic [TIME_BITS-1:0]   exp_mem  [TABLE_DEPTH];
  logic                   mem_we;
  logic [IDX_BITS-1:0]    mem_widx;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0]   out_addr_q, out_addr_d;
  status_e                out_status_q, out_status_d;
  logic                   out_changed_q, out_changed_d;
  logic                   out_last_q, out_last_d;

  logic                   out_free;
  logic                   scan_match;
  logic                   scan_free;
  logic                   scan_stall;

  assign req.ready          = (state_q == ST_IDLE);
  assign rsp.valid          = out_valid_q;
  assign rsp.result_address = out_addr_q;
  assign rsp.status         = out_status_q;
  assign rsp.set_changed    = out_changed_q;
  assign rsp.last           = out_last_q;

  assign out_free = !out_valid_q || rsp.ready;

  // shared compare unit: expiry check for expire, address match otherwise
  always_comb begin
    if (op_q == OP_EXPIRE) begin
      scan_match = valid_q[idx_q] && is_before(exp_mem[idx_q], now_q);
    end else begin
      scan_match = valid_q[idx_q] && (addr_mem[idx_q] == addr_q);
    end
    scan_free  = !valid_q[idx_q];
    scan_stall = (op_q == OP_EXPIRE) && scan_match && pend_q && !out_free;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    op_d          = op_q;
    addr_d        = addr_q;
    now_d         = now_q;
    expiry_d      = expiry_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    pend_d        = pend_q;
    pend_addr_d   = pend_addr_q;
    valid_d       = valid_q;
    mem_we        = 1'b0;
    mem_widx      = hit_idx_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_addr_d    = out_addr_q;
    out_status_d  = out_status_q;
    out_changed_d = out_changed_q;
    out_last_d    = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          op_d     = opcode_e'(req.opcode);
          addr_d   = req.neighbor_address;
          now_d    = req.now_time;
          expiry_d = TIME_BITS'(req.now_time + hold_q);
          idx_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          pend_d   = 1'b0;
          if (opcode_e'(req.opcode) != OP_RESERVED) begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (!scan_stall) begin
          if (op_q == OP_EXPIRE) begin
            // hold each expired address until the next one shows it is not last
            if (scan_match) begin
              valid_d[idx_q] = 1'b0;
              if (pend_q) begin
                out_valid_d   = 1'b1;
                out_addr_d    = pend_addr_q;
                out_status_d  = STAT_EXPIRED;
                out_changed_d = 1'b1;
                out_last_d    = 1'b0;
              end
              pend_d      = 1'b1;
              pend_addr_d = addr_mem[idx_q];
            end
          end else begin
            if (scan_match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
            end
            if (scan_free && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q;
            end
          end
          idx_d = idx_q + 1'b1;
          if (idx_q == IDX_BITS'(TABLE_DEPTH - 1)) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          state_d       = ST_IDLE;
          out_valid_d   = 1'b1;
          out_addr_d    = addr_q;
          out_last_d    = 1'b1;
          out_changed_d = 1'b0;
          case (op_q)
            OP_EXPIRE: begin
              if (pend_q) begin
                out_addr_d    = pend_addr_q;
                out_status_d  = STAT_EXPIRED;
                out_changed_d = 1'b1;
              end else begin
                out_addr_d   = '0;
                out_status_d = STAT_NONE_EXPIRED;
              end
              pend_d = 1'b0;
            end
            OP_ADVERTISE: begin
              if (hit_q) begin
                mem_we       = 1'b1;
                mem_widx     = hit_idx_q;
                out_status_d = STAT_REFRESHED;
              end else if (free_q) begin
                mem_we            = 1'b1;
                mem_widx          = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                out_status_d      = STAT_INSERTED;
                out_changed_d     = 1'b1;
              end else begin
                out_status_d = STAT_DROPPED;
              end
            end
            OP_DELETE: begin
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
                out_status_d       = STAT_DELETED;
                out_changed_d      = 1'b1;
              end else begin
                out_status_d = STAT_NOT_FOUND;
              end
            end
            default: begin
              out_valid_d = out_valid_q && !rsp.ready;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      pend_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      hold_q      <= HOLD_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    addr_q        <= addr_d;
    now_q         <= now_d;
    expiry_q      <= expiry_d;
    hit_idx_q     <= hit_idx_d;
    free_idx_q    <= free_idx_d;
    pend_addr_q   <= pend_addr_d;
    out_addr_q    <= out_addr_d;
    out_status_q  <= out_status_d;
    out_changed_q <= out_changed_d;
    out_last_q    <= out_last_d;
  end

  // table entry write: insert or refresh
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[mem_widx] <= addr_q;
      exp_mem[mem_widx]  <= expiry_q;
    end
  end

  // checks
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready && (req.opcode != OP_RESERVED) |=> state_q == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_scan_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SCAN) |-> idx_q == '0)
    else $error("scan did not start at entry zero");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && out_free |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
    else $error("finish did not deliver a last result");

  a_pend_expire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && (state_q != ST_IDLE) |-> op_q == OP_EXPIRE)
    else $error("pending expired address outside an expire");

endmodule

FILE: tb/tb_timed_neighbor_selector_table_core.sv
// ----------------------------------------------------------------------------
// tb_timed_neighbor_selector_table_core: self-checking neighbor table bench
// Runs a directed table of requests, then random advertise, expire, delete and
// reserved-opcode traffic under several hold times. A local table model predicts
// each result unless a directed row gives a typed one, and each result is checked
// in order. The sender and receiver idle at random but for the last two segments.
// ----------------------------------------------------------------------------
module tb_timed_neighbor_selector_table_core;
  import tnst_pkg::*;

  localparam int MAX_RESULTS  = 16;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SEGMENTS     = 6;
  localparam int SEG_REQUESTS = 36;
  localparam int POOL_SIZE    = 24;
  localparam int DIR_ROWS     = 26;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    status_e              status;
    logic                 changed;
    logic                 last;
  } nbr_result_t;

  typedef enum logic {CHK_PREDICT, CHK_TYPED} row_check_e;

  typedef struct {
    opcode_e              op;
    logic [ADDR_BITS-1:0] addr;
    logic [TIME_BITS-1:0] now;
    row_check_e           chk;
    logic [ADDR_BITS-1:0] exp_addr;
    status_e              exp_status;
    logic                 exp_changed;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [HOLD_BITS-1:0] cfg_wdata_i;

  tnst_req_if req_bus ();
  tnst_rsp_if rsp_bus ();

  timed_neighbor_selector_table_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // local copy of the table and the hold register
  logic                 nbr_valid  [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] nbr_addr   [TABLE_DEPTH];
  logic [TIME_BITS-1:0] nbr_expiry [TABLE_DEPTH];
  logic [HOLD_BITS-1:0] hold_ticks;

  nbr_result_t pending_results[$];

  int errors;
  int requests_sent;
  int results_seen;
  int expired_seen;
  int dropped_seen;
  int src_idle_pct;
  int sink_stall_pct;

  // directed requests; typed expectations only where obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_EXPIRE,    32'h0000_0000, 32'h0000_0000, CHK_TYPED,   32'h0, STAT_NONE_EXPIRED, 1'b0},
    '{OP_DELETE,    32'hFFFF_FFFF, 32'h0000_0000, CHK_TYPED,   32'hFFFF_FFFF, STAT_NOT_FOUND, 1'b0},
    '{OP_ADVERTISE, 32'h0000_0000, 32'h0000_0000, CHK_TYPED,   32'h0, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_TYPED,   32'hFFFF_FFFF, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'h0000_0000, 32'h0000_000A, CHK_TYPED,   32'h0, STAT_REFRESHED, 1'b0},
    '{OP_RESERVED,  32'h5A5A_5A5A, 32'hA5A5_A5A5, CHK_PREDICT, 32'h0, STAT_INSERTED, 1'b0},
    '{OP_EXPIRE,    32'h0000_0000, 32'h0000_0006, CHK_PREDICT, 32'h0, STAT_INSERTED, 1'b0},
    '{OP_DELETE,    32'h0000_0000, 32'h0000_0000, CHK_TYPED,   32'h0, STAT_DELETED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0001, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0001, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0002, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0002, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0003, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0003, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0004, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0004, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0005, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0005, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0006, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0006, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0007, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0007, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0008, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0008, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0009, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0009, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000A, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000A, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000B, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000B, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000C, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000C, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000D, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000D, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000E, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000E, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_000F, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_000F, STAT_INSERTED, 1'b1},
    '{OP_ADVERTISE, 32'hC0A8_0010, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0010, STAT_INSERTED, 1'b1},
    // table full
    '{OP_ADVERTISE, 32'hC0A8_0011, 32'h7FFF_FFF0, CHK_TYPED,   32'hC0A8_0011, STAT_DROPPED, 1'b0},
    // exactly half the time range later: every entry counts as expired
    '{OP_EXPIRE,    32'h0000_0000, 32'hFFFF_FFF6, CHK_PREDICT, 32'h0, STAT_INSERTED, 1'b0}
  };

  // hold time per random segment, extremes included
  logic [HOLD_BITS-1:0] seg_hold [SEGMENTS] = '{
    32'd0, 32'hFFFF_FFFF, 32'd40, 32'h8000_0000, 32'd3, 32'h7FFF_FFFF
  };

  // 4 time unit clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // wrapped difference with the top bit set means the expiry has passed
  function automatic logic expiry_passed(input logic [TIME_BITS-1:0] expiry,
                                         input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] diff;
    diff = expiry - now;
    return diff[TIME_BITS-1];
  endfunction

  // apply one request to the local table and queue the results it causes
  function automatic void update_neighbor_table(input opcode_e op,
                                                input logic [ADDR_BITS-1:0] addr,
                                                input logic [TIME_BITS-1:0] now);
    int hit;
    int free_slot;
    int n;
    logic [TIME_BITS-1:0] expiry;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    expiry    = now + hold_ticks;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (nbr_valid[i] && nbr_addr[i] == addr && hit < 0) hit = i;
      if (!nbr_valid[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      OP_ADVERTISE: begin
        if (hit >= 0) begin
          nbr_expiry[hit] = expiry;
          pending_results.push_back('{addr, STAT_REFRESHED, 1'b0, 1'b1});
        end else if (free_slot >= 0) begin
          nbr_valid[free_slot]  = 1'b1;
          nbr_addr[free_slot]   = addr;
          nbr_expiry[free_slot] = expiry;
          pending_results.push_back('{addr, STAT_INSERTED, 1'b1, 1'b1});
        end else begin
          pending_results.push_back('{addr, STAT_DROPPED, 1'b0, 1'b1});
        end
      end
      OP_EXPIRE: begin
        for (int i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++) begin
          if (nbr_valid[i] && expiry_passed(nbr_expiry[i], now)) begin
            nbr_valid[i] = 1'b0;
            pending_results.push_back('{nbr_addr[i], STAT_EXPIRED, 1'b1, 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          pending_results.push_back('{'0, STAT_NONE_EXPIRED, 1'b0, 1'b1});
        end else begin
          pending_results[pending_results.size()-1].last = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          nbr_valid[hit] = 1'b0;
          pending_results.push_back('{addr, STAT_DELETED, 1'b1, 1'b1});
        end else begin
          pending_results.push_back('{addr, STAT_NOT_FOUND, 1'b0, 1'b1});
        end
      end
      default: ;
    endcase
  endfunction

  // drive one request, wait for the handshake, then maybe idle
  task automatic send_request(input opcode_e op, input logic [ADDR_BITS-1:0] addr,
                              input logic [TIME_BITS-1:0] now, input logic typed,
                              input nbr_result_t typed_result);
    req_bus.valid            <= 1'b1;
    req_bus.opcode           <= op;
    req_bus.neighbor_address <= addr;
    req_bus.now_time         <= now;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    update_neighbor_table(op, addr, now);
    if (typed) pending_results[pending_results.size()-1] = typed_result;
    requests_sent++;
    if ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // hold off requests until every result is in, then let the block settle
  task automatic wait_until_drained(input int settle);
    int waited;
    waited = 0;
    req_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
    repeat (settle) @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    nbr_result_t want;
    if (rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (rsp_bus.status == STAT_EXPIRED) expired_seen++;
      if (rsp_bus.status == STAT_DROPPED) dropped_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: addr %h status %0d changed %0d last %0d",
                 $time, rsp_bus.result_address, rsp_bus.status,
                 rsp_bus.set_changed, rsp_bus.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.result_address !== want.addr || rsp_bus.status !== want.status ||
            rsp_bus.set_changed !== want.changed || rsp_bus.last !== want.last) begin
          $display("%0t mismatch: expected addr %h status %0d changed %0d last %0d",
                   $time, want.addr, want.status, want.changed, want.last);
          $display("%0t           actual   addr %h status %0d changed %0d last %0d",
                   $time, rsp_bus.result_address, rsp_bus.status,
                   rsp_bus.set_changed, rsp_bus.last);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
    logic [TIME_BITS-1:0] clock_ticks;
    logic [ADDR_BITS-1:0] addr;
    opcode_e              op;
    nbr_result_t          typed_result;
    int                   sent;
    int                   pick;

    errors         = 0;
    requests_sent  = 0;
    results_seen   = 0;
    expired_seen   = 0;
    dropped_seen   = 0;
    src_idle_pct   = 12;
    sink_stall_pct = 88;
    hold_ticks     = HOLD_RESET;
    foreach (nbr_valid[i]) nbr_valid[i] = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    clock_ticks = $urandom();

    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_wdata_i              <= '0;
    req_bus.valid            <= 1'b0;
    req_bus.opcode           <= OP_ADVERTISE;
    req_bus.neighbor_address <= '0;
    req_bus.now_time         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset hold time
    for (int r = 0; r < DIR_ROWS; r++) begin
      typed_result = '{dir_rows[r].exp_addr, dir_rows[r].exp_status,
                       dir_rows[r].exp_changed, 1'b1};
      send_request(dir_rows[r].op, dir_rows[r].addr, dir_rows[r].now,
                   dir_rows[r].chk == CHK_TYPED, typed_result);
    end

    // random segments, one hold time each
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_until_drained(SETTLE_CYCLES);
      if (s == 2) begin
        src_idle_pct   = 88;
        sink_stall_pct = 12;
      end else if (s == 4) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= seg_hold[s];
      @(posedge clk_i);
      hold_ticks = seg_hold[s];
      cfg_we_i <= 1'b0;

      sent = 0;
      while (sent < SEG_REQUESTS) begin
        // once, hold the sender back until the table has answered everything
        if (s == 0 && sent == SEG_REQUESTS / 2) wait_until_drained(0);
        pick = $urandom_range(99);
        if (pick < 50) op = OP_ADVERTISE;
        else if (pick < 75) op = OP_EXPIRE;
        else if (pick < 95) op = OP_DELETE;
        else op = OP_RESERVED;
        addr = ($urandom_range(9) == 0) ? $urandom() : addr_pool[$urandom_range(POOL_SIZE-1)];
        // mostly a slowly advancing clock, now and then a jump
        if ($urandom_range(19) == 0) clock_ticks = $urandom();
        else clock_ticks = clock_ticks + $urandom_range(6);
        send_request(op, addr, clock_ticks, 1'b0, typed_result);
        if (op != OP_RESERVED) sent++;
      end
    end

    wait_until_drained(SETTLE_CYCLES);
    if (pending_results.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Covered %0d requests over %0d hold settings; checked %0d results",
             requests_sent, SEGMENTS + 1, results_seen);
    $display("including %0d expirations and %0d drops on a full table; %0d errors",
             expired_seen, dropped_seen, errors);
    if (errors == 0) begin
      $display("timed_neighbor_selector_table_core regression: pass");
    end else begin
      $display("timed_neighbor_selector_table_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("%0t watchdog expired", $time);
    $display("timed_neighbor_selector_table_core regression: fail");
    $finish;
  end

endmodule
